// ===== rtl/core/aes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and round functions of the AES-128 encrypt unit.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned BLOCK_W     = 128;
  localparam int unsigned HALF_W      = 64;
  localparam int unsigned ROUNDS      = 10;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] GF_POLY  = 8'h1B;
  localparam logic [7:0] GF_TOP   = 8'h80;
  localparam logic [7:0] SBOX_AFF = 8'h63;

  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  typedef logic [BLOCK_W-1:0] block_t;

  function automatic logic [7:0] gf_dbl(input logic [7:0] v);
    logic [7:0] r;
    r = {v[6:0], 1'b0};
    if ((v & GF_TOP) != 8'h00) r = r ^ GF_POLY;
    return r;
  endfunction

  // Product in GF(2^8) modulo the AES polynomial (0x11B), by shift and add.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = gf_dbl(x);
    end
    return p;
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] v);
    logic [7:0] inv;
    logic [7:0] sq;
    logic [7:0] s;
    inv = 8'h01;
    sq  = v;
    for (int i = 1; i < 8; i++) begin
      sq  = gf_mul(sq, sq);
      inv = gf_mul(inv, sq);
    end
    for (int i = 0; i < 8; i++) begin
      s[i] = inv[i] ^ inv[(i+4)%8] ^ inv[(i+5)%8] ^ inv[(i+6)%8] ^ inv[(i+7)%8]
             ^ SBOX_AFF[i];
    end
    return s;
  endfunction

  typedef logic [7:0] sbox_tab_t [256];

  function automatic sbox_tab_t sbox_build();
    sbox_tab_t t;
    for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
    return t;
  endfunction

  localparam sbox_tab_t SBOX = sbox_build();

  // Byte i sits at bits [127-8i -: 8].
  function automatic logic [7:0] byte_at(input block_t b, input int i);
    return b[BLOCK_W-1-8*i -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t b);
    block_t o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[BLOCK_W-1-8*(r+4*c) -: 8] = SBOX[byte_at(b, r + 4*((c+r)%4))];
    return o;
  endfunction

  function automatic block_t mix_cols(input block_t b);
    block_t o;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_at(b, 4*c);
      a1 = byte_at(b, 4*c+1);
      a2 = byte_at(b, 4*c+2);
      a3 = byte_at(b, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      o[BLOCK_W-1-8*(4*c)   -: 8] = a0 ^ al ^ gf_dbl(a0 ^ a1);
      o[BLOCK_W-1-8*(4*c+1) -: 8] = a1 ^ al ^ gf_dbl(a1 ^ a2);
      o[BLOCK_W-1-8*(4*c+2) -: 8] = a2 ^ al ^ gf_dbl(a2 ^ a3);
      o[BLOCK_W-1-8*(4*c+3) -: 8] = a3 ^ al ^ gf_dbl(a3 ^ a0);
    end
    return o;
  endfunction

  // One step of the key schedule: four words from the previous round key.
  function automatic block_t next_key(input block_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ===== rtl/core/aes_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_front
// Input queue: takes plaintext words and feeds them to the round pipeline.
// ----------------------------------------------------------------------------
module aes_front #(
  parameter int unsigned DEPTH = aes_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  aes_pkg::block_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output aes_pkg::block_t out_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  aes_pkg::block_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != (AW+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ===== rtl/core/aes_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_back
// Round pipeline (initial key add plus ten rounds) with the key schedule carried
// alongside; it advances when the last stage is empty or the output takes a word.
// ----------------------------------------------------------------------------
module aes_back (
  input  logic            clk,
  input  logic            rst,
  input  aes_pkg::block_t key,
  input  logic            in_valid,
  output logic            in_ready,
  input  aes_pkg::block_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output aes_pkg::block_t out_data
);

  localparam int unsigned NR = aes_pkg::ROUNDS;

  aes_pkg::block_t st   [NR+1];
  aes_pkg::block_t rk   [NR+1];
  logic [7:0]      rc   [NR+1];
  logic            vld  [NR+1];
  logic            advance;

  // Stall only when the last stage holds a word the output cannot take.
  assign advance   = !vld[NR] || out_ready;
  assign in_ready  = advance;
  assign out_valid = vld[NR];
  assign out_data  = st[NR];

  always_ff @(posedge clk) begin
    if (advance) begin
      st[0] <= in_data ^ key;
      rk[0] <= key;
      rc[0] <= 8'h01;
      for (int i = 1; i <= NR; i++) begin
        rk[i] <= aes_pkg::next_key(rk[i-1], rc[i-1]);
        rc[i] <= aes_pkg::gf_dbl(rc[i-1]);
        if (i == NR)
          st[i] <= aes_pkg::sub_shift(st[i-1]) ^ aes_pkg::next_key(rk[i-1], rc[i-1]);
        else
          st[i] <= aes_pkg::mix_cols(aes_pkg::sub_shift(st[i-1]))
                   ^ aes_pkg::next_key(rk[i-1], rc[i-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NR; i++) vld[i] <= 1'b0;
    end else if (advance) begin
      vld[0] <= in_valid;
      for (int i = 1; i <= NR; i++) vld[i] <= vld[i-1];
    end
  end

endmodule

// ===== rtl/core/aes128_block_encrypt_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_encrypt_unit
// AES-128 encryption of one 128-bit block per word, key from two registers.
// ----------------------------------------------------------------------------
// Usage:
//   cfg: write index 0 for key bytes 0..7, index 1 for bytes 8..15; other
//   indexes are ignored. Write the key only while no block is in flight.
//   s_axis: plaintext word, tdata = {plain_low, plain_high} (plain_high low).
//   m_axis: ciphertext word, tdata = {cipher_low, cipher_high} (cipher_high low).
// Throughput: one block per cycle while m_axis_tready stays high. An input queue
//   feeds an eleven-stage pipeline (initial key add plus ten rounds, each round
//   one stage with its round key computed in the same stage).
// Reset clears the queue, the pipeline valid bits and both key registers.
// With m_axis_tready low and the last stage full, the pipe holds; the queue keeps
//   taking words until its four entries are full, then drops s_axis_tready.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_unit #(
  parameter int unsigned QUEUE_DEPTH = aes_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // plain_high [63:0], plain_low [127:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // cipher_high [63:0], cipher_low [127:64]
);

  logic [63:0]     key_high;
  logic [63:0]     key_low;
  logic            q_valid;
  logic            q_ready;
  aes_pkg::block_t q_data;
  aes_pkg::block_t in_blk;
  aes_pkg::block_t out_blk;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        aes_pkg::CFG_KEY_HIGH: key_high <= cfg_data;
        aes_pkg::CFG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Block byte 0 at the top: plain_high then plain_low.
  assign in_blk       = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
  assign m_axis_tdata = {out_blk[63:0], out_blk[127:64]};

  aes_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (in_blk),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  aes_back u_back (
    .clk       (clk),
    .rst       (rst),
    .key       ({key_high, key_low}),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_data   (q_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_blk)
  );

endmodule

// ===== rtl/core/aes_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_checker
// Port-level checks of the encrypt unit, bound to the top level.
// ----------------------------------------------------------------------------
module aes_checker (
  input logic         clk,
  input logic         rst,
  input logic         cfg_ready,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);

  // Hold a stalled output word.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");

  // Nothing comes out right after reset.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // Key port never stalls.
  assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("cfg port stalled");

  // The emptied input queue takes a word right after reset.
  assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("input not ready right after reset");

endmodule

bind aes128_block_encrypt_unit aes_checker u_aes_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_ready     (cfg_ready),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/aes128_block_encrypt_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_encrypt_unit_tb
// Self-checking bench for the AES-128 block encrypt unit: directed vectors
// (known-answer blocks, all-zero and all-one data and keys) and random blocks
// under several keys are compared against known answers or an in-bench cipher
// model, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_unit_tb;

  localparam int LATENCY   = 12;
  localparam int N_RANDOM  = 1830;
  localparam int MAX_CYCLE = 400000;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } half_pair_t;

  typedef struct {
    half_pair_t plain;
    bit         known;
    half_pair_t cipher;
  } vec_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_index = aes_pkg::CFG_KEY_HIGH;
  logic [63:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  aes128_block_encrypt_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  logic [7:0]  sub_tab [256];
  logic [63:0] key_hi_q, key_lo_q;
  half_pair_t  cipher_pending [$];
  int          fail_count = 0;
  int          cipher_seen = 0;
  int          cycle_count = 0;
  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;

  function automatic logic [7:0] xtime(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

  // build the S-box from inverse plus affine map
  function automatic logic [7:0] sub_byte_calc(logic [7:0] v);
    logic [7:0] inv, a, b, p, s;
    inv = 8'h00;
    for (int c = 1; c < 256; c++) begin
      a = v; b = c[7:0]; p = 8'h00;
      for (int i = 0; i < 8; i++) begin
        if (b[i]) p = p ^ a;
        a = xtime(a);
      end
      if (p == 8'h01) inv = c[7:0];
    end
    for (int i = 0; i < 8; i++)
      s[i] = inv[i] ^ inv[(i+4)%8] ^ inv[(i+5)%8] ^ inv[(i+6)%8] ^ inv[(i+7)%8]
             ^ aes_pkg::SBOX_AFF[i];
    return s;
  endfunction

  function automatic half_pair_t encrypt_block(logic [63:0] khi, logic [63:0] klo,
                                               half_pair_t pt);
    logic [7:0] rk [176];
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] t [4];
    logic [7:0] rc, first, a0, a1, a2, a3, al;
    half_pair_t res;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) begin
      rk[i]   = khi[63-8*i -: 8];
      rk[8+i] = klo[63-8*i -: 8];
      st[i]   = pt.hi[63-8*i -: 8];
      st[8+i] = pt.lo[63-8*i -: 8];
    end
    for (int w = 4; w < 44; w++) begin
      for (int j = 0; j < 4; j++) t[j] = rk[(w-1)*4+j];
      if (w % 4 == 0) begin
        first = t[0];
        t[0] = sub_tab[t[1]] ^ rc;
        t[1] = sub_tab[t[2]];
        t[2] = sub_tab[t[3]];
        t[3] = sub_tab[first];
        rc = xtime(rc);
      end
      for (int j = 0; j < 4; j++) rk[w*4+j] = rk[(w-4)*4+j] ^ t[j];
    end
    for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          tmp[r+4*c] = sub_tab[st[r + 4*((c+r)%4)]];
      st = tmp;
      if (rnd < 10)
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
          st[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
          st[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
          st[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
        end
      for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[16*rnd+i];
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = st[i];
      res.lo[63-8*i -: 8] = st[8+i];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h (t=%0t)", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[aes128_block_encrypt_unit] ERROR");
      $finish;
    end
  end

  // sink: random stall, check each accepted word
  always @(posedge clk) begin
    half_pair_t want;
    half_pair_t got;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        // cipher_high sits in the low half of tdata
        got = {m_axis_tdata[63:0], m_axis_tdata[127:64]};
        cipher_seen++;
        if (cipher_pending.size() == 0) begin
          report_mismatch("unexpected word", got.hi, got.lo);
        end else begin
          want = cipher_pending.pop_front();
          if (got.hi !== want.hi) report_mismatch("cipher_high", got.hi, want.hi);
          if (got.lo !== want.lo) report_mismatch("cipher_low", got.lo, want.lo);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic write_key(logic idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == aes_pkg::CFG_KEY_HIGH) key_hi_q = val; else key_lo_q = val;
  endtask

  task automatic set_key(logic [63:0] khi, logic [63:0] klo);
    write_key(aes_pkg::CFG_KEY_HIGH, khi);
    write_key(aes_pkg::CFG_KEY_LOW, klo);
  endtask

  task automatic drain();
    while (cipher_pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // hold the word until accepted; expected value is taken at acceptance
  task automatic send_block(half_pair_t pt, bit known, half_pair_t ct);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pt.lo, pt.hi};
    do @(posedge clk); while (!s_axis_tready);
    cipher_pending.push_back(known ? ct : encrypt_block(key_hi_q, key_lo_q, pt));
  endtask

  task automatic idle_src();
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic half_pair_t rand_pair();
    half_pair_t p;
    p.hi = {$urandom, $urandom};
    p.lo = {$urandom, $urandom};
    return p;
  endfunction

  vec_row_t vec_tab [] = '{
    // FIPS-197 appendix C.1 style vector under key 00..0f
    '{'{64'h0011223344556677, 64'h8899aabbccddeeff}, 1,
      '{64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a}},
    '{'{64'h0, 64'h0}, 0, '{64'h0, 64'h0}},
    '{'{64'hffffffffffffffff, 64'hffffffffffffffff}, 0, '{64'h0, 64'h0}},
    '{'{64'h8000000000000000, 64'h0}, 0, '{64'h0, 64'h0}},
    '{'{64'h0, 64'h0000000000000001}, 0, '{64'h0, 64'h0}},
    '{'{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555}, 0, '{64'h0, 64'h0}}
  };

  initial begin
    half_pair_t none;
    logic [63:0] khi, klo;
    int sel;
    none = '0;
    for (int i = 0; i < 256; i++) sub_tab[i] = sub_byte_calc(i[7:0]);
    key_hi_q = '0;
    key_lo_q = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset key is all zero: known answer for zero plaintext
    send_block('{64'h0, 64'h0}, 1, '{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});
    idle_src();
    drain();

    set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    foreach (vec_tab[i]) send_block(vec_tab[i].plain, vec_tab[i].known, vec_tab[i].cipher);
    idle_src();
    drain();
    set_key('1, '1);
    foreach (vec_tab[i]) send_block(vec_tab[i].plain, 0, none);
    idle_src();
    drain();
    // writes to the high half only must keep the low half
    write_key(aes_pkg::CFG_KEY_HIGH, 64'h0);
    for (int i = 0; i < 4; i++) send_block(rand_pair(), 0, none);
    idle_src();
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 9 : (ph == 1) ? 58 : 0;
      sink_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 9 : 0;
      for (int n = 0; n < N_RANDOM / 3; n++) begin
        if (n % 100 == 0) begin
          idle_src();
          drain();
          sel = $urandom_range(3);
          khi = (sel == 0) ? 64'h0 : (sel == 1) ? '1 : {$urandom, $urandom};
          klo = (sel == 0) ? 64'h0 : (sel == 1) ? '1 : {$urandom, $urandom};
          set_key(khi, klo);
        end
        send_block(rand_pair(), 0, none);
      end
    end
    idle_src();
    drain();

    $display("covered %0d ciphertext words over directed vectors and random keys",
             cipher_seen);
    $display("idle mixes: sender/receiver 9/58, 58/9, none; key extremes all-0 and all-1");
    if (fail_count == 0)
      $display("[aes128_block_encrypt_unit] OK");
    else
      $display("[aes128_block_encrypt_unit] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/aes_pkg.sv
rtl/core/aes_front.sv
rtl/core/aes_back.sv
rtl/core/aes128_block_encrypt_unit.sv
rtl/core/aes_checker.sv
tb/sv/aes128_block_encrypt_unit_tb.sv
